// File: rtl/itrgb_pkg.sv
// itrgb_pkg: shared types and constants for the iteration-to-rgb palette block
// used by itrgb_div and iteration_to_rgb_palette; no dependencies
`default_nettype none

package itrgb_pkg;

    // default number of fraction bits of the normalized count
    localparam int unsigned FRACTION_BITS_DEF = 16;

    // width of the iteration count and of the iteration limit
    localparam int unsigned LIMIT_W = 16;

    // register reset values
    localparam logic [LIMIT_W-1:0] MAX_ITER_RST = 16'd100;

    // polynomial gains, each folded with the 255 channel scale
    localparam logic [12:0] P1_GAIN = 13'd2295;   // 9 * 255
    localparam logic [12:0] P2_GAIN = 13'd3825;   // 15 * 255
    localparam logic [12:0] P3_GAIN = 13'd4335;   // 17 * 255, halved after the product

    // register index taken from paddr[2]
    typedef enum logic [0:0] {
        REG_MAX_ITERATIONS   = 1'b0,
        REG_PALETTE_ROTATION = 1'b1
    } t_reg_index;

    // channel assignment of the three polynomials
    typedef enum logic [1:0] {
        ROT_RGB   = 2'd0,   // r=p1 g=p2 b=p3
        ROT_BRG   = 2'd1,   // r=p3 g=p1 b=p2
        ROT_GBR   = 2'd2,   // r=p2 g=p3 b=p1
        ROT_BLACK = 2'd3
    } t_rotation;

endpackage

`default_nettype wire

// File: rtl/itrgb_div.sv
// itrgb_div: pipelined restoring divider, one quotient bit per register stage
// forms the fraction rem * 2^FRACTION_BITS / limit for rem < limit; uses itrgb_pkg
`default_nettype none

module itrgb_div
    import itrgb_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_vld,
    input  wire logic                     i_one,
    input  wire logic [LIMIT_W-1:0]       i_rem,
    input  wire logic [LIMIT_W-1:0]       i_limit,
    output logic                          o_vld,
    output logic                          o_one,
    output logic [FRACTION_BITS-1:0]      o_quo
);

    // per-stage registers; the last stage keeps no remainder
    logic                     r_vld [FRACTION_BITS];
    logic                     r_one [FRACTION_BITS];
    logic [FRACTION_BITS-1:0] r_quo [FRACTION_BITS];
    logic [LIMIT_W-1:0]       r_rem [FRACTION_BITS-1];

    logic [LIMIT_W:0] w_limit;

    assign w_limit = {1'b0, i_limit};

    for (genvar k = 0; k < FRACTION_BITS; k++) begin : g_stage
        logic                     w_vld_in;
        logic                     w_one_in;
        logic [LIMIT_W-1:0]       w_rem_in;
        logic [FRACTION_BITS-1:0] w_quo_in;
        logic [LIMIT_W:0]         w_shift;
        logic [LIMIT_W:0]         w_diff;
        logic                     w_bit;

        // stage input from the ports or the stage before
        if (k == 0) begin : g_first
            assign w_vld_in = i_vld;
            assign w_one_in = i_one;
            assign w_rem_in = i_rem;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_vld_in = r_vld[k-1];
            assign w_one_in = r_one[k-1];
            assign w_rem_in = r_rem[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        // shift in a zero, subtract the limit when it fits
        assign w_shift = {w_rem_in, 1'b0};
        assign w_diff  = w_shift - w_limit;
        assign w_bit   = (w_shift >= w_limit);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_one[k] <= w_one_in;
                r_quo[k] <= {w_quo_in[FRACTION_BITS-2:0], w_bit};
            end
        end

        // remainder only where a later stage needs it
        if (k < FRACTION_BITS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_bit ? w_diff[LIMIT_W-1:0] : w_shift[LIMIT_W-1:0];
                end
            end
        end
    end

    assign o_vld = r_vld[FRACTION_BITS-1];
    assign o_one = r_one[FRACTION_BITS-1];
    assign o_quo = r_quo[FRACTION_BITS-1];

endmodule

`default_nettype wire

// File: rtl/iteration_to_rgb_palette.sv
// iteration_to_rgb_palette: maps an escape iteration count to a packed rgb color
// top level; uses itrgb_pkg and itrgb_div
`default_nettype none

// Takes one pixel per clock while the output is not stalled and returns one
// color per request, in order. The pipeline holds an input register,
// FRACTION_BITS divider stages that each resolve one bit of t = count /
// max_iterations, a register for t and 1 - t, two product stages, and a
// gain-and-channel stage that is also the output register; the divider
// pipeline sets the depth. When i_stall holds a valid output, the whole
// pipeline freezes and one more request is taken into a skid register, so
// o_stall rises in the following cycle and i_stall never reaches o_stall
// through logic. A limit of zero acts as one. Configuration registers
// (max_iterations at 0x0, palette_rotation at 0x4) are written over the apb
// port; the user must do so with the block idle, which is not enforced.
module iteration_to_rgb_palette
    import itrgb_pkg::*;
#(
    parameter int unsigned FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // pixel request channel
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [15:0]   i_iteration_count,
    // color channel
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [23:0]        o_pixel_color,
    // register port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned FB = FRACTION_BITS;
    localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

    // configuration registers
    logic [LIMIT_W-1:0] r_max_iterations;
    t_rotation          r_rotation;
    t_reg_index         w_reg_index;
    logic               w_cfg_wr;

    assign pready      = 1'b1;
    assign w_reg_index = t_reg_index'(paddr[2]);
    assign w_cfg_wr    = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_iterations <= MAX_ITER_RST;
            r_rotation       <= ROT_RGB;
        end else if (w_cfg_wr) begin
            case (w_reg_index)
                REG_MAX_ITERATIONS:   r_max_iterations <= pwdata[LIMIT_W-1:0];
                REG_PALETTE_ROTATION: r_rotation       <= t_rotation'(pwdata[1:0]);
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (w_reg_index)
            REG_MAX_ITERATIONS:   prdata = {{(32-LIMIT_W){1'b0}}, r_max_iterations};
            REG_PALETTE_ROTATION: prdata = {30'd0, r_rotation};
            default:              prdata = '0;
        endcase
    end

    // pipeline advance and skid register
    logic               w_en;
    logic               r_skid_vld;
    logic [LIMIT_W-1:0] r_skid_count;
    logic               r_out_vld;

    assign w_en    = !(r_out_vld && i_stall);
    assign o_stall = r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (w_en) begin
            r_skid_vld <= 1'b0;
        end else if (i_valid && !r_skid_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && i_valid && !r_skid_vld) begin
            r_skid_count <= i_iteration_count;
        end
    end

    // input stage: clamp the count and flag t = 1
    logic [LIMIT_W-1:0] w_limit;
    logic [LIMIT_W-1:0] w_count;
    logic               w_one;
    logic               r_in_vld;
    logic               r_in_one;
    logic [LIMIT_W-1:0] r_in_rem;

    assign w_limit = (r_max_iterations == '0) ? LIMIT_W'(1) : r_max_iterations;
    assign w_count = r_skid_vld ? r_skid_count : i_iteration_count;
    assign w_one   = (w_count >= w_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_en) begin
            r_in_vld <= r_skid_vld | i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_one <= w_one;
            r_in_rem <= w_one ? '0 : w_count;
        end
    end

    // fraction bits of t
    logic          w_div_vld;
    logic          w_div_one;
    logic [FB-1:0] w_div_quo;

    itrgb_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_in_vld),
        .i_one   (r_in_one),
        .i_rem   (r_in_rem),
        .i_limit (w_limit),
        .o_vld   (w_div_vld),
        .o_one   (w_div_one),
        .o_quo   (w_div_quo)
    );

    // t and its complement
    logic        r_t_vld;
    logic [FB:0] r_t;
    logic [FB:0] r_u;
    logic [FB:0] w_t;

    assign w_t = w_div_one ? ONE : {1'b0, w_div_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else if (w_en) begin
            r_t_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t <= w_t;
            r_u <= ONE - w_t;
        end
    end

    // first products: t^2, u^2, t*u
    logic            r_a_vld;
    logic [FB:0]     r_tt;
    logic [FB:0]     r_uu;
    logic [FB:0]     r_tu;
    logic [2*FB+1:0] w_tt;
    logic [2*FB+1:0] w_uu;
    logic [2*FB+1:0] w_tu;

    assign w_tt = r_t * r_t;
    assign w_uu = r_u * r_u;
    assign w_tu = r_t * r_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= r_t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tt <= w_tt[2*FB:FB];
            r_uu <= w_uu[2*FB:FB];
            r_tu <= w_tu[2*FB:FB];
        end
    end

    // second products: u*t^3, u^2*t^2, u^3*t
    logic            r_b_vld;
    logic [FB:0]     r_q1;
    logic [FB:0]     r_q2;
    logic [FB:0]     r_q3;
    logic [2*FB+1:0] w_q1;
    logic [2*FB+1:0] w_q2;
    logic [2*FB+1:0] w_q3;

    assign w_q1 = r_tu * r_tt;
    assign w_q2 = r_uu * r_tt;
    assign w_q3 = r_uu * r_tu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_q1 <= w_q1[2*FB:FB];
            r_q2 <= w_q2[2*FB:FB];
            r_q3 <= w_q3[2*FB:FB];
        end
    end

    // gains, channel select and output register
    logic [FB+13:0] w_m1;
    logic [FB+13:0] w_m2;
    logic [FB+13:0] w_m3;
    logic [7:0]     w_p1;
    logic [7:0]     w_p2;
    logic [7:0]     w_p3;
    logic [23:0]    w_color;
    logic [23:0]    r_color;

    assign w_m1 = P1_GAIN * r_q1;
    assign w_m2 = P2_GAIN * r_q2;
    assign w_m3 = P3_GAIN * r_q3;
    assign w_p1 = w_m1[FB+7:FB];
    assign w_p2 = w_m2[FB+7:FB];
    assign w_p3 = w_m3[FB+8:FB+1];

    always_comb begin
        case (r_rotation)
            ROT_RGB:   w_color = {w_p1, w_p2, w_p3};
            ROT_BRG:   w_color = {w_p3, w_p1, w_p2};
            ROT_GBR:   w_color = {w_p2, w_p3, w_p1};
            ROT_BLACK: w_color = '0;
            default:   w_color = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_color <= w_color;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_pixel_color = r_color;

`ifndef SYNTHESIS
    // the normalized count never exceeds one
    a_t_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t_vld |-> (r_t <= ONE))
        else $error("normalized count above one");

    // the skid register fills only from a request taken while stall was low
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(i_valid && !o_stall))
        else $error("skid filled without a request");

    // the skid register holds a request only behind a stalled output
    a_skid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> $past(r_out_vld && i_stall))
        else $error("skid occupied without an output stall");
`endif

endmodule

`default_nettype wire
